### rtl/core/kdlp_pkg.sv
// Package for the key debounce and long-press block: sizes, event and
// register codes, the per-key state record and the structs between modules.
// No dependencies.
package kdlp_pkg;

  localparam int NUM_KEYS  = 4;
  localparam int RAW_BITS  = 4;
  localparam int KEY_W     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int IDX_W     = 2;
  localparam int DEB_W     = 8;
  localparam int HOLD_W    = 16;
  localparam int EV_W      = 2;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int MOD_STEPS = HOLD_W / 2;
  localparam int STEP_W    = $clog2(MOD_STEPS);

  localparam logic [HOLD_W-1:0] HOLD_MAX = 16'hFFFF;

  localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EV_W-1:0] EV_SHORT  = 2'd1;
  localparam logic [EV_W-1:0] EV_LONG   = 2'd2;
  localparam logic [EV_W-1:0] EV_REPEAT = 2'd3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_LONG     = 2'd1;
  localparam logic [1:0] REG_REPEAT   = 2'd2;
  localparam logic [1:0] REG_RELEASE  = 2'd3;

  localparam logic [DEB_W-1:0]  DEB_RST = 8'd3;
  localparam logic [HOLD_W-1:0] LONG_RST = 16'd50;
  localparam logic [HOLD_W-1:0] RPT_RST  = 16'd10;
  localparam logic              REL_RST  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_MOD
  } st_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ticks;
    logic [HOLD_W-1:0] long_press_ticks;
    logic [HOLD_W-1:0] repeat_interval;
    logic              release_level;
  } cfg_t;

  typedef struct packed {
    logic              stable;
    logic [DEB_W-1:0]  cnt;
    logic [HOLD_W-1:0] hold;
    logic              long_done;
    logic [EV_W-1:0]   pend;
  } key_ent_t;

  typedef struct packed {
    logic              start;
    logic [HOLD_W-1:0] dividend;
    logic [HOLD_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_rsp_t;

endpackage

### rtl/core/kdlp_in_if.sv
// Input channel of the key debounce block: valid, ready and the item fields.
// Depends on kdlp_pkg.
interface kdlp_in_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [kdlp_pkg::RAW_BITS-1:0]  raw_levels;
  logic [kdlp_pkg::IDX_W-1:0]     key_index;

  modport source (output valid, output op, output raw_levels, output key_index, input ready);
  modport sink   (input valid, input op, input raw_levels, input key_index, output ready);
endinterface

### rtl/core/kdlp_out_if.sv
// Result channel of the key debounce block: valid, ready and the event code.
// Depends on kdlp_pkg.
interface kdlp_out_if;
  logic                       valid;
  logic                       ready;
  logic [kdlp_pkg::EV_W-1:0]  event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

### rtl/core/kdlp_cfg_regs.sv
// APB-style configuration registers of the key debounce block.
// Depends on kdlp_pkg.
module kdlp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kdlp_pkg::ADDR_W-1:0]   paddr,
  input  logic [kdlp_pkg::DATA_W-1:0]   pwdata,
  output logic [kdlp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output kdlp_pkg::cfg_t                cfg
);
  import kdlp_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_DEBOUNCE: cfg_nxt.debounce_ticks   = pwdata[DEB_W-1:0];
        REG_LONG:     cfg_nxt.long_press_ticks = pwdata[HOLD_W-1:0];
        REG_REPEAT:   cfg_nxt.repeat_interval  = pwdata[HOLD_W-1:0];
        REG_RELEASE:  cfg_nxt.release_level    = pwdata[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DEBOUNCE: prdata = DATA_W'(cfg_r.debounce_ticks);
      REG_LONG:     prdata = DATA_W'(cfg_r.long_press_ticks);
      REG_REPEAT:   prdata = DATA_W'(cfg_r.repeat_interval);
      REG_RELEASE:  prdata = DATA_W'(cfg_r.release_level);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEB_RST;
      cfg_r.long_press_ticks <= LONG_RST;
      cfg_r.repeat_interval  <= RPT_RST;
      cfg_r.release_level    <= REL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/core/kdlp_mod_unit.sv
// Iterative remainder unit: restoring division, two quotient bits a cycle.
// Reports whether the remainder is zero. Depends on kdlp_pkg.
module kdlp_mod_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  kdlp_pkg::mod_req_t  req,
  output kdlp_pkg::mod_rsp_t  rsp
);
  import kdlp_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [HOLD_W-1:0] rem_r, rem_nxt;
  logic [HOLD_W-1:0] dvd_r, dvd_nxt;
  logic [HOLD_W-1:0] dvs_r, dvs_nxt;
  logic [HOLD_W-1:0] rem_mid;

  // One restoring step; the partial remainder stays below the divisor.
  function automatic logic [HOLD_W-1:0] rem_step(input logic [HOLD_W-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [HOLD_W-1:0] d);
    logic [HOLD_W:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[HOLD_W-1:0];
  endfunction

  assign rem_mid = rem_step(rem_r, dvd_r[HOLD_W-1], dvs_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = rem_step(rem_mid, dvd_r[HOLD_W-2], dvs_r);
      dvd_nxt = {dvd_r[HOLD_W-3:0], 2'b00};
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_W'(MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.rem_zero = (rem_r == '0);

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r && !done_r)
    else $error("remainder unit started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("remainder done without a run");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && !req.start |=> !busy_r)
    else $error("remainder unit became busy without a start");
`endif

endmodule

### rtl/core/kdlp_ctrl.sv
// Sequencer and per-key state of the key debounce block: walks the keys on a
// scan tick, handles reads and holds the result register. Depends on kdlp_pkg.
module kdlp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  kdlp_pkg::cfg_t      cfg,
  kdlp_in_if.sink             in_ch,
  kdlp_out_if.source          out_ch,
  output kdlp_pkg::mod_req_t  mod_req,
  input  kdlp_pkg::mod_rsp_t  mod_rsp
);
  import kdlp_pkg::*;

  st_t                 state_r, state_nxt;
  key_ent_t            keys_r [NUM_KEYS];
  logic [KEY_W-1:0]    k_r, k_nxt;
  logic [NUM_KEYS-1:0] lvl_r, lvl_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [EV_W-1:0]     out_code_r, out_code_nxt;

  logic                        accept, tick_acc, read_acc, idx_ok;
  logic [KEY_W-1:0]            rd_idx;
  key_ent_t                    cur, ent_nxt;
  logic                        ent_we, go_mod, advance, last_key;
  logic                        lvl;
  logic [DEB_W-1:0]            cnt_inc;
  logic [HOLD_W-1:0]           hold_new;
  logic [RAW_BITS+NUM_KEYS-1:0] lvl_pad;

  assign accept   = in_ch.valid && in_ch.ready;
  assign tick_acc = accept && (in_ch.op == OP_TICK);
  assign read_acc = accept && (in_ch.op == OP_READ);
  assign idx_ok   = (32'(in_ch.key_index) < NUM_KEYS);
  assign rd_idx   = (state_r == ST_IDLE) ? KEY_W'(in_ch.key_index) : k_r;
  assign cur      = keys_r[rd_idx];
  assign lvl      = lvl_r[0];
  assign last_key = (k_r == KEY_W'(NUM_KEYS - 1));
  // Keys beyond the raw bits always see the released level.
  assign lvl_pad  = {{NUM_KEYS{cfg.release_level}}, in_ch.raw_levels};
  assign cnt_inc  = cur.cnt + DEB_W'(1);
  assign hold_new = (cur.hold != HOLD_MAX) ? cur.hold + HOLD_W'(1) : cur.hold;

  // Per-key update.
  always_comb begin
    ent_nxt = cur;
    ent_we  = 1'b0;
    go_mod  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (read_acc && idx_ok) begin
          ent_we       = 1'b1;
          ent_nxt.pend = EV_NONE;
        end
      end
      ST_KEY: begin
        ent_we = 1'b1;
        if (lvl != cur.stable) begin
          if (cnt_inc >= cfg.debounce_ticks) begin
            ent_nxt.stable    = lvl;
            ent_nxt.cnt       = '0;
            ent_nxt.hold      = '0;
            ent_nxt.long_done = 1'b0;
            if (lvl != cfg.release_level) begin
              ent_nxt.pend = EV_SHORT;
            end
          end else begin
            ent_nxt.cnt = cnt_inc;
          end
        end else begin
          ent_nxt.cnt = '0;
          if (lvl != cfg.release_level) begin
            ent_nxt.hold = hold_new;
            if (!cur.long_done && (hold_new >= cfg.long_press_ticks)) begin
              ent_nxt.pend      = EV_LONG;
              ent_nxt.long_done = 1'b1;
            end else if (cur.long_done && (cfg.repeat_interval != '0)) begin
              go_mod = 1'b1;
            end
          end
        end
      end
      ST_MOD: begin
        if (mod_rsp.done && mod_rsp.rem_zero) begin
          ent_we       = 1'b1;
          ent_nxt.pend = EV_REPEAT;
        end
      end
      default: begin
        ent_we = 1'b0;
      end
    endcase
  end

  assign advance = ((state_r == ST_KEY) && !go_mod) || ((state_r == ST_MOD) && mod_rsp.done);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (tick_acc) state_nxt = ST_KEY;
      ST_KEY: begin
        if (go_mod) begin
          state_nxt = ST_MOD;
        end else if (last_key) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MOD: begin
        if (mod_rsp.done) begin
          state_nxt = last_key ? ST_IDLE : ST_KEY;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ch.ready   = 1'b0;
    mod_req.start = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready   = !out_valid_r || out_ch.ready;
      ST_KEY:  mod_req.start = go_mod;
      ST_MOD:  in_ch.ready   = 1'b0;
      default: in_ch.ready   = 1'b0;
    endcase
  end

  assign mod_req.dividend = hold_new - cfg.long_press_ticks;
  assign mod_req.divisor  = cfg.repeat_interval;

  always_comb begin
    k_nxt   = k_r;
    lvl_nxt = lvl_r;
    if (tick_acc) begin
      k_nxt   = '0;
      lvl_nxt = lvl_pad[NUM_KEYS-1:0];
    end else if (advance) begin
      k_nxt   = k_r + KEY_W'(1);
      lvl_nxt = lvl_r >> 1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    if (read_acc) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = idx_ok ? cur.pend : EV_NONE;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_code = out_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        keys_r[i].stable    <= REL_RST;
        keys_r[i].cnt       <= '0;
        keys_r[i].hold      <= '0;
        keys_r[i].long_done <= 1'b0;
        keys_r[i].pend      <= EV_NONE;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      if (ent_we) begin
        keys_r[rd_idx] <= ent_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    out_code_r <= out_code_nxt;
  end

`ifndef SYNTHESIS
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    read_acc |=> out_valid_r)
    else $error("read transfer gave no result");
  a_tick_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> (state_r == ST_KEY) && (k_r == '0))
    else $error("scan tick did not start the key walk");
  a_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == ST_MOD))
    else $error("remainder result outside the wait state");
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (32'(k_r) < NUM_KEYS))
    else $error("key counter out of range");
`endif

endmodule

### rtl/core/key_debounce_long_press_top.sv
// Top level of the key debounce and long-press block.
// Depends on kdlp_pkg, kdlp_in_if, kdlp_out_if and the kdlp_* modules.
// A read transfer gives its result in the output register in the cycle after it.
// A scan tick holds the input while the sequencer walks the keys, and longer for each
// held key that needs a repeat test in the shared remainder unit.
// Reset (rst_n, synchronous, active low) restores register defaults and released keys.
module key_debounce_long_press_top (
  input  logic                          clk,
  input  logic                          rst_n,
  kdlp_in_if.sink                       in_ch,
  kdlp_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kdlp_pkg::ADDR_W-1:0]   paddr,
  input  logic [kdlp_pkg::DATA_W-1:0]   pwdata,
  output logic [kdlp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import kdlp_pkg::*;

  // Live configuration; the user must write it only while the block is idle (not enforced here).
  cfg_t     cfg;
  // Request and status between the key sequencer and the remainder unit.
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  // Register file on the configuration port.
  kdlp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The sequencer visits one key a cycle on a scan tick, but waits out each repeat
  // test. A read transfer is served in the idle state, and the result register lets a
  // new item be taken in the same cycle as the waiting result is transferred.
  kdlp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mod_req (mod_req),
    .mod_rsp (mod_rsp)
  );

  // The repeat test needs (hold - long) modulo the interval; one shared
  // remainder unit settles it in eight steps of two bits each.
  kdlp_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

endmodule

### tb/sv/kdlp_event_checker.sv
// Scoreboard for the key debounce and long-press block: follows register writes,
// mirrors the per-key debounce state and checks every event code read back.
// Depends on kdlp_pkg, kdlp_in_if and kdlp_out_if.
module kdlp_event_checker
  import kdlp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  kdlp_in_if                in_ch,
  kdlp_out_if               out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                mismatches,
  output int                awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              level;
    logic [DEB_W-1:0]  settle;
    logic [HOLD_W-1:0] held;
    logic              long_seen;
    logic [EV_W-1:0]   latched;
  } key_track_t;

  typedef struct packed {
    logic [IDX_W-1:0] key;
    logic [EV_W-1:0]  code;
  } read_exp_t;

  key_track_t        keys [NUM_KEYS];
  read_exp_t         pending_reads [$];
  logic [DEB_W-1:0]  deb_need;
  logic [HOLD_W-1:0] long_need;
  logic [HOLD_W-1:0] repeat_gap;
  logic              rel_lvl;
  int                fail_count = 0;

  // One scan tick over every key: debounce, then hold counting and event latching.
  function automatic void scan_keys(input logic [RAW_BITS-1:0] raw);
    logic              lvl;
    logic [HOLD_W-1:0] since;
    for (int k = 0; k < NUM_KEYS; k++) begin
      lvl = (k < RAW_BITS) ? raw[k] : rel_lvl;
      if (lvl != keys[k].level) begin
        keys[k].settle = keys[k].settle + 1'b1;
        if (keys[k].settle >= deb_need) begin
          keys[k].level     = lvl;
          keys[k].settle    = '0;
          keys[k].held      = '0;
          keys[k].long_seen = 1'b0;
          if (lvl != rel_lvl) begin
            keys[k].latched = EV_SHORT;
          end
        end
      end else begin
        keys[k].settle = '0;
        if (lvl != rel_lvl) begin
          if (keys[k].held != HOLD_MAX) begin
            keys[k].held = keys[k].held + 1'b1;
          end
          // Distance past the long-press point wraps at 16 bits.
          since = keys[k].held - long_need;
          if (!keys[k].long_seen && keys[k].held >= long_need) begin
            keys[k].latched   = EV_LONG;
            keys[k].long_seen = 1'b1;
          end else if (keys[k].long_seen && repeat_gap != '0 && since % repeat_gap == '0) begin
            keys[k].latched = EV_REPEAT;
          end
        end
      end
    end
  endfunction

  function automatic logic [EV_W-1:0] take_event(input logic [IDX_W-1:0] idx);
    logic [EV_W-1:0] code;
    code = EV_NONE;
    if (idx < NUM_KEYS) begin
      code = keys[idx].latched;
      keys[idx].latched = EV_NONE;
    end
    return code;
  endfunction

  function automatic void note_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endfunction

  always @(posedge clk) begin : observe
    read_exp_t head;
    if (!rst_n) begin
      deb_need   = DEB_RST;
      long_need  = LONG_RST;
      repeat_gap = RPT_RST;
      rel_lvl    = REL_RST;
      foreach (keys[k]) begin
        keys[k]       = '0;
        keys[k].level = REL_RST;
      end
      pending_reads.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_DEBOUNCE: deb_need   = pwdata[DEB_W-1:0];
          REG_LONG:     long_need  = pwdata[HOLD_W-1:0];
          REG_REPEAT:   repeat_gap = pwdata[HOLD_W-1:0];
          REG_RELEASE:  rel_lvl    = pwdata[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_READ) begin
          head.key  = in_ch.key_index;
          head.code = take_event(in_ch.key_index);
          pending_reads.push_back(head);
        end else begin
          scan_keys(in_ch.raw_levels);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_reads.size() == 0) begin
          note_mismatch($sformatf("event %0d arrived with no read waiting",
                                  out_ch.event_code));
        end else begin
          head = pending_reads.pop_front();
          if (out_ch.event_code !== head.code) begin
            note_mismatch($sformatf("key %0d read: expected event %0d, got %0d",
                                    head.key, head.code, out_ch.event_code));
          end
        end
      end
    end
    mismatches <= fail_count;
    awaited    <= pending_reads.size();
  end

endmodule

### tb/sv/key_debounce_long_press_top_tb.sv
// Top of the testbench for the key debounce and long-press block: clock, reset,
// register writes, key stimulus and the verdict.
// Depends on kdlp_pkg, kdlp_in_if, kdlp_out_if, kdlp_event_checker and the block.
module key_debounce_long_press_top_tb;
  import kdlp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Styles of the result sink between its long hold-offs.
  localparam int SINK_OPEN   = 0;
  localparam int SINK_COIN   = 1;
  localparam int SINK_SPARSE = 2;
  localparam int SINK_PULSE  = 3;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                mismatches;
  int                awaited;
  int                burst_left = 0;
  int                hold_requests = 0;

  kdlp_in_if  in_ch ();
  kdlp_out_if out_ch ();

  key_debounce_long_press_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  kdlp_event_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offers one item and returns at the edge of its transfer. The sender works in
  // bursts: when a burst runs out, valid drops for a random, non-empty gap, so it is
  // never lowered and raised again within the same time step.
  // Now and then a long burst gives a stretch with no idling at all.
  task automatic send_item(input logic op, input logic [RAW_BITS-1:0] raw,
                           input logic [IDX_W-1:0] idx);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = ($urandom_range(4) == 0) ? 150 : int'($urandom_range(30, 1));
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.raw_levels <= raw;
    in_ch.key_index  <= idx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Brings the block to rest: no offer, every read answered, and then enough
  // cycles for a scan tick with repeat tests on every key to finish, since a tick
  // leaves no result behind to wait for.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (64) @(posedge clk);
  endtask

  // Setup and access cycle; the register takes the data at the access edge.
  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Registers are only ever rewritten once the block has gone quiet.
  task automatic apply_setup(input logic [DEB_W-1:0] deb, input logic [HOLD_W-1:0] hold_long,
                             input logic [HOLD_W-1:0] gap, input logic rel);
    drain();
    write_reg(REG_DEBOUNCE, DATA_W'(deb));
    write_reg(REG_LONG, DATA_W'(hold_long));
    write_reg(REG_REPEAT, DATA_W'(gap));
    write_reg(REG_RELEASE, DATA_W'(rel));
  endtask

  // Plays keys the way a person would press them: each key keeps its intended
  // level for a random number of ticks before flipping, single-tick bounce noise
  // is laid on top, and a few ticks carry arbitrary levels. Reads of random keys
  // are mixed in at the given percentage.
  task automatic play_keys(input int n_items, input int read_pct, input int dur_lo,
                           input int dur_hi, input int noise_pct);
    logic [RAW_BITS-1:0] aim;
    logic [RAW_BITS-1:0] raw;
    int                  left [RAW_BITS];
    aim = RAW_BITS'($urandom);
    foreach (left[k]) left[k] = $urandom_range(dur_hi, dur_lo);
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(99) < read_pct) begin
        send_item(OP_READ, RAW_BITS'($urandom), IDX_W'($urandom));
      end else begin
        foreach (left[k]) begin
          if (left[k] == 0) begin
            aim[k]  = ~aim[k];
            left[k] = $urandom_range(dur_hi, dur_lo);
          end
          left[k]--;
        end
        raw = aim;
        if ($urandom_range(99) < noise_pct) begin
          raw[$urandom_range(RAW_BITS-1)] ^= 1'b1;
        end
        if ($urandom_range(99) < 3) begin
          raw = RAW_BITS'($urandom);
        end
        send_item(OP_TICK, raw, IDX_W'($urandom));
      end
    end
  endtask

  // Result sink. Each hold-off asked for by the stimulus keeps ready low for a
  // long stretch counted here, while the sender keeps offering reads; otherwise
  // the sink moves through segments of random style and length.
  initial begin : result_sink
    int seg_left;
    int style;
    int holds_served;
    int stall;
    out_ch.ready <= 1'b0;
    seg_left     = 0;
    style        = SINK_OPEN;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        stall        = $urandom_range(300, 150);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          style    = $urandom_range(3);
          seg_left = $urandom_range(64, 8);
        end
        seg_left--;
        case (style)
          SINK_OPEN:   out_ch.ready <= 1'b1;
          SINK_COIN:   out_ch.ready <= 1'($urandom_range(1));
          SINK_SPARSE: out_ch.ready <= ($urandom_range(3) == 0);
          default:     out_ch.ready <= (seg_left % 4 != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [RAW_BITS-1:0] raw;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_TICK;
    in_ch.raw_levels <= '0;
    in_ch.key_index  <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    rst_n            <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults after reset: three pressed ticks settle every key and
    // latch a short press.
    repeat (3) send_item(OP_TICK, 4'b0000, '0);
    send_item(OP_READ, 4'b1111, 2'd0);

    // Zero debounce and zero long-press count, repeat on every tick. The keys are
    // already held, so the next tick latches the long press and the one after it
    // a repeat, overwriting the short press still pending on key 1.
    apply_setup(8'd0, 16'd0, 16'd1, 1'b1);
    send_item(OP_TICK, 4'b0000, 2'd3);
    send_item(OP_TICK, 4'b0000, 2'd0);
    send_item(OP_READ, 4'b0000, 2'd1);
    send_item(OP_READ, 4'b0000, 2'd0);
    // Release of all keys clears the hold state but leaves pending events alone.
    send_item(OP_TICK, 4'b1111, 2'd0);
    send_item(OP_READ, 4'b0000, 2'd2);
    send_item(OP_READ, 4'b0000, 2'd3);
    send_item(OP_READ, 4'b0000, 2'd3);
    send_item(OP_TICK, 4'b0101, 2'd0);
    send_item(OP_READ, 4'b0000, 2'd1);
    send_item(OP_READ, 4'b0000, 2'd0);

    // Release level flipped at run time: stable levels stay, so keys 0 and 2 now
    // count as held at once and keys 1 and 3 see a fresh press.
    drain();
    write_reg(REG_RELEASE, DATA_W'(1'b0));
    send_item(OP_TICK, 4'b1111, 2'd0);
    send_item(OP_TICK, 4'b0000, 2'd0);
    for (int k = 0; k < NUM_KEYS; k++) send_item(OP_READ, 4'b0000, IDX_W'(k));

    // Random key play under a range of settings, extremes among them. The first
    // phase opens with a long sink hold-off and many reads, so the output backs
    // up and the input stalls.
    apply_setup(8'd1, 16'd5, 16'd3, 1'b1);
    hold_requests++;
    play_keys(100, 40, 1, 20, 5);
    apply_setup(8'd3, 16'd50, 16'd10, 1'b1);
    play_keys(100, 20, 5, 80, 5);
    apply_setup(8'd2, 16'd8, 16'd0, 1'b0);
    hold_requests++;
    play_keys(80, 30, 1, 25, 5);
    apply_setup(8'd255, 16'd1, 16'hFFFF, 1'b1);
    play_keys(100, 10, 250, 300, 1);
    apply_setup(8'd1, 16'd0, 16'd1, 1'b0);
    play_keys(60, 40, 1, 12, 5);
    apply_setup(DEB_W'($urandom_range(6, 1)), HOLD_W'($urandom_range(20)),
                HOLD_W'($urandom_range(7)), 1'($urandom_range(1)));
    play_keys(60, 30, 1, 30, 5);

    // Long hold: keys 0 and 2 stay pressed for many ticks, so the long press
    // latches once and repeats follow at every third tick after it.
    // Single-tick glitches must be filtered out.
    apply_setup(8'd4, 16'd40, 16'd3, 1'b1);
    for (int n = 0; n < 80; n++) begin
      if ($urandom_range(15) == 0) begin
        send_item(OP_READ, RAW_BITS'($urandom), IDX_W'($urandom));
      end else begin
        raw = 4'b1010;
        if ($urandom_range(31) == 0) begin
          raw[$urandom_range(RAW_BITS-1)] ^= 1'b1;
        end
        send_item(OP_TICK, raw, IDX_W'($urandom));
      end
    end
    for (int k = 0; k < NUM_KEYS; k++) send_item(OP_READ, 4'b0000, IDX_W'(k));

    drain();
    if (mismatches == 0 && awaited == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // The slowest correct run stays well below the limit of this watchdog.
  initial begin : watchdog
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule

### files.f
rtl/core/kdlp_pkg.sv
rtl/core/kdlp_in_if.sv
rtl/core/kdlp_out_if.sv
rtl/core/kdlp_cfg_regs.sv
rtl/core/kdlp_mod_unit.sv
rtl/core/kdlp_ctrl.sv
rtl/core/key_debounce_long_press_top.sv
tb/sv/kdlp_event_checker.sv
tb/sv/key_debounce_long_press_top_tb.sv
